>>> design/ttdc_pkg.sv
// ----------------------------------------------------------------------------
// ttdc_pkg
// Shared constants, command type and glyph lookup functions for the
// text-to-tile draw command unit.
// ----------------------------------------------------------------------------
package ttdc_pkg;

    localparam int GRID_COLS   = 40;
    localparam int GRID_ROWS   = 30;
    localparam int TILE_PIXELS = 16;

    localparam int COL_W   = 6;
    localparam int ROW_W   = 5;
    localparam int GLYPH_W = 6;
    localparam int PROD_W  = 16;

    localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(GRID_COLS);
    localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(GRID_ROWS);

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    localparam logic [GLYPH_W-1:0] GLYPH_UNKNOWN = 6'd36;
    localparam logic [GLYPH_W-1:0] GLYPH_PERIOD  = 6'd37;
    localparam logic [GLYPH_W-1:0] GLYPH_COLON   = 6'd38;
    localparam logic [GLYPH_W-1:0] GLYPH_BANG    = 6'd39;
    localparam logic [GLYPH_W-1:0] GLYPH_DIGIT0  = 6'd26;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
    } cmd_t;

    // Glyph order: A..Z, 0..9, then ? . : !
    function automatic logic [GLYPH_W-1:0] glyph_index(input logic [7:0] ch);
        logic [7:0] up;
        logic [7:0] diff;
        up = ch;
        if (ch >= 8'h61 && ch <= 8'h7A) begin
            up = ch - 8'h20;
        end
        diff = 8'h00;
        glyph_index = GLYPH_UNKNOWN;
        if (up >= 8'h41 && up <= 8'h5A) begin
            diff = up - 8'h41;
            glyph_index = diff[GLYPH_W-1:0];
        end else if (up >= 8'h30 && up <= 8'h39) begin
            diff = up - 8'h30;
            glyph_index = GLYPH_DIGIT0 + diff[GLYPH_W-1:0];
        end else if (up == 8'h2E) begin
            glyph_index = GLYPH_PERIOD;
        end else if (up == 8'h3A) begin
            glyph_index = GLYPH_COLON;
        end else if (up == 8'h21) begin
            glyph_index = GLYPH_BANG;
        end
    endfunction

    // Glyphs sit in 2x2 blocks, eight blocks per band, two bands.
    function automatic logic [3:0] glyph_sheet_col(input logic [GLYPH_W-1:0] g);
        glyph_sheet_col = {g[4:2], g[0]};
    endfunction

    function automatic logic [1:0] glyph_sheet_row(input logic [GLYPH_W-1:0] g);
        glyph_sheet_row = {(g >= 6'd32), g[1]};
    endfunction

endpackage

>>> design/ttdc_front.sv
// ----------------------------------------------------------------------------
// ttdc_front
// Accepts character transactions, keeps the tile cursor and pushes one draw
// command into the queue for every drawable character placed inside the grid.
// ----------------------------------------------------------------------------
module ttdc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [7:0]                     char_code,
    input  logic                           start_of_string,
    input  logic signed [10:0]             origin_col,
    input  logic signed [10:0]             origin_row,
    output logic                           push,
    output ttdc_pkg::cmd_t                 push_cmd
);

    logic [ttdc_pkg::COL_W-1:0] cursor_col_reg, cursor_col_next;
    logic [ttdc_pkg::ROW_W-1:0] cursor_row_reg, cursor_row_next;
    logic [ttdc_pkg::COL_W-1:0] home_col_reg, home_col_next;
    logic                       stopped_reg, stopped_next;

    logic [ttdc_pkg::COL_W-1:0] col_eff, home_eff;
    logic [ttdc_pkg::ROW_W-1:0] row_eff;
    logic                       stopped_eff;
    logic [9:0]                 ocol_raw, orow_raw;
    logic                       neg;

    always_comb
    begin
        ocol_raw = origin_col[9:0];
        orow_raw = origin_row[9:0];
        neg      = origin_col[10] | origin_row[10];

        col_eff     = cursor_col_reg;
        row_eff     = cursor_row_reg;
        home_eff    = home_col_reg;
        stopped_eff = stopped_reg;

        if (start_of_string) begin
            if (neg) begin
                stopped_eff = 1'b1;
            end else begin
                home_eff = (ocol_raw > 10'(ttdc_pkg::GRID_COLS)) ?
                           ttdc_pkg::COL_LIMIT : ocol_raw[ttdc_pkg::COL_W-1:0];
                col_eff  = home_eff;
                row_eff  = (orow_raw > 10'(ttdc_pkg::GRID_ROWS)) ?
                           ttdc_pkg::ROW_LIMIT : orow_raw[ttdc_pkg::ROW_W-1:0];
                stopped_eff = 1'b0;
            end
        end

        cursor_col_next = col_eff;
        cursor_row_next = row_eff;
        home_col_next   = home_eff;
        stopped_next    = stopped_eff;
        push            = 1'b0;

        push_cmd.glyph = ttdc_pkg::glyph_index(char_code);
        push_cmd.col   = col_eff;
        push_cmd.row   = row_eff;

        if (!stopped_eff) begin
            if (char_code == ttdc_pkg::CH_SPACE) begin
                if (col_eff < ttdc_pkg::COL_LIMIT) begin
                    cursor_col_next = col_eff + 1'b1;
                end
            end else if (char_code == ttdc_pkg::CH_NEWLINE) begin
                cursor_col_next = home_eff;
                if (row_eff < ttdc_pkg::ROW_LIMIT) begin
                    cursor_row_next = row_eff + 1'b1;
                end
            end else if (col_eff >= ttdc_pkg::COL_LIMIT ||
                         row_eff >= ttdc_pkg::ROW_LIMIT) begin
                stopped_next = 1'b1;
            end else begin
                push            = in_fire;
                cursor_col_next = col_eff + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            home_col_reg   <= '0;
            stopped_reg    <= 1'b1;
        end else if (in_fire) begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
            home_col_reg   <= home_col_next;
            stopped_reg    <= stopped_next;
        end
    end

endmodule

>>> design/ttdc_queue.sv
// ----------------------------------------------------------------------------
// ttdc_queue
// Short first-in first-out queue of draw commands between front and back.
// ----------------------------------------------------------------------------
module ttdc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ttdc_pkg::cmd_t push_cmd,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output ttdc_pkg::cmd_t head_cmd
);

    ttdc_pkg::cmd_t                 slot_reg [ttdc_pkg::QUEUE_DEPTH];
    logic [ttdc_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ttdc_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == ttdc_pkg::QCNT_W'(ttdc_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> design/ttdc_back.sv
// ----------------------------------------------------------------------------
// ttdc_back
// Takes draw commands from the queue, maps the glyph to its spritesheet tile,
// scales the cursor to pixels and holds the result in the output register.
// ----------------------------------------------------------------------------
module ttdc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  ttdc_pkg::cmd_t cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [3:0]     sheet_col,
    output logic [1:0]     sheet_row,
    output logic [9:0]     pixel_x,
    output logic [8:0]     pixel_y
);

    logic                          valid_reg;
    logic [3:0]                    sheet_col_reg;
    logic [1:0]                    sheet_row_reg;
    logic [9:0]                    pixel_x_reg;
    logic [8:0]                    pixel_y_reg;
    logic [ttdc_pkg::PROD_W-1:0]   px_full, py_full;

    assign pop     = cmd_valid && (!valid_reg || out_ready);
    assign px_full = ttdc_pkg::PROD_W'(cmd.col) * ttdc_pkg::PROD_W'(ttdc_pkg::TILE_PIXELS);
    assign py_full = ttdc_pkg::PROD_W'(cmd.row) * ttdc_pkg::PROD_W'(ttdc_pkg::TILE_PIXELS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            sheet_col_reg <= ttdc_pkg::glyph_sheet_col(cmd.glyph);
            sheet_row_reg <= ttdc_pkg::glyph_sheet_row(cmd.glyph);
            pixel_x_reg   <= px_full[9:0];
            pixel_y_reg   <= py_full[8:0];
        end
    end

    assign out_valid = valid_reg;
    assign sheet_col = sheet_col_reg;
    assign sheet_row = sheet_row_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;

endmodule

>>> design/text_to_tile_draw_commands_unit.sv
// ----------------------------------------------------------------------------
// text_to_tile_draw_commands_unit
// Turns a stream of character bytes into tile draw commands with pixel
// positions.
// ----------------------------------------------------------------------------
// One character is taken per clock while the queue is not full. The front end
// updates the tile cursor in the cycle a character transaction is accepted, so
// the cursor loop sets the rate of one character per cycle. Drawable characters
// enter a four-entry command queue; the back end maps each to its spritesheet
// tile and pixel position and presents it in an output register. Input is held
// off only while the queue is full.
module text_to_tile_draw_commands_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], origin_col[18:8], origin_row[29:19]
    input  logic        s_tuser,   // start_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sheet_col[3:0], sheet_row[5:4], pixel_x[15:6], pixel_y[24:16]
);

    logic           in_fire;
    logic           push;
    ttdc_pkg::cmd_t push_cmd;
    logic           pop;
    logic           full;
    logic           not_empty;
    ttdc_pkg::cmd_t head_cmd;
    logic [3:0]     sheet_col;
    logic [1:0]     sheet_row;
    logic [9:0]     pixel_x;
    logic [8:0]     pixel_y;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    ttdc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .char_code       (s_tdata[7:0]),
        .start_of_string (s_tuser),
        .origin_col      (s_tdata[18:8]),
        .origin_row      (s_tdata[29:19]),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ttdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head_cmd  (head_cmd)
    );

    ttdc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (not_empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sheet_col (sheet_col),
        .sheet_row (sheet_row),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y)
    );

    assign m_tdata = {7'b0, pixel_y, pixel_x, sheet_row, sheet_col};

endmodule
